FILE: sv/mmrt_pkg.sv
`default_nettype none
package mmrt_pkg;

    localparam logic [31:0] TYPE_RAM      = 32'd1;
    localparam logic [31:0] TYPE_RESERVED = 32'd2;

    typedef enum logic [2:0] {
        OP_APPEND  = 3'd0,
        OP_ALLOC   = 3'd1,
        OP_RESERVE = 3'd2,
        OP_COMPACT = 3'd3,
        OP_READ    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_NOFIT = 2'd2,
        STS_CROSS = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS,
        S_DRAIN,
        S_CALC,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        PS_APPEND,
        PS_READ,
        PS_ASCAN,
        PS_AAPPLY,
        PS_RESV,
        PS_CTRANS,
        PS_CDROP
    } pass_t;

    typedef struct packed {
        logic [63:0] base;
        logic [63:0] length;
        logic [31:0] rtype;
    } entry_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [63:0] entry_base;
        logic [63:0] entry_length;
        logic [31:0] entry_type;
        logic [63:0] alloc_size;
        logic [63:0] alloc_limit;
        logic [63:0] reserve_start;
        logic [63:0] reserve_end;
        logic [4:0]  read_index;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] alloc_address;
        logic [63:0] read_base;
        logic [63:0] read_length;
        logic [31:0] read_type;
        logic [5:0]  entries_used;
    } rsp_t;

endpackage
`default_nettype wire

FILE: sv/mmrt_cell.sv
`default_nettype none
module mmrt_cell (
    input  wire                    aclk,
    input  wire                    shift,
    input  wire mmrt_pkg::entry_t  d_in,
    output mmrt_pkg::entry_t       q
);
    import mmrt_pkg::*;

    entry_t ent_reg;

    always_ff @(posedge aclk) begin
        if (shift) begin
            ent_reg <= d_in;
        end
    end

    assign q = ent_reg;

endmodule
`default_nettype wire

FILE: sv/mmrt_ctrl.sv
`default_nettype none
module mmrt_ctrl #(
    parameter int MAX_REGIONS = 32,
    parameter int PAGE_BITS   = 12
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire mmrt_pkg::req_t  req,
    input  wire                  merge_en,
    input  wire mmrt_pkg::entry_t head,
    input  wire mmrt_pkg::entry_t nxt,
    output logic                 shift,
    output mmrt_pkg::entry_t     tail,
    output logic                 m_valid,
    input  wire                  m_ready,
    output mmrt_pkg::rsp_t       rsp
);
    import mmrt_pkg::*;

    localparam int IDX_W = $clog2(MAX_REGIONS);
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam int SCN_W = $clog2(MAX_REGIONS + 2);
    localparam int RI_W  = (CNT_W > 5) ? CNT_W : 5;
    localparam logic [63:0] PG_MASK  = (64'd1 << PAGE_BITS) - 64'd1;
    localparam logic [63:0] ST_LIMIT = ~PG_MASK;
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_REGIONS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_REGIONS - 1);

    state_t state_reg, state_next;
    pass_t  pass_reg, pass_next;
    logic [IDX_W-1:0] c_reg, c_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;
    logic             s1_valid_reg, s1_valid_next;
    logic             merged_reg, merged_next;
    logic             found_reg, found_next;
    logic             exact_reg, exact_next;
    logic             inserted_reg, inserted_next;
    logic             stopped_reg, stopped_next;
    logic             skip_reg, skip_next;
    logic [SCN_W-1:0] scan_reg, scan_next;

    req_t             req_reg, req_next;
    rsp_t             rsp_reg, rsp_next;
    logic [63:0]      size_reg, size_next;
    logic [1:0]       status_reg, status_next;
    logic [63:0]      addr_reg, addr_next;
    entry_t           rd_reg, rd_next;
    entry_t           pend_reg, pend_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [63:0]      cand_reg, cand_next;
    logic [63:0]      fend_reg, fend_next;
    logic [63:0]      nl_reg, nl_next;
    logic [IDX_W-1:0] s1_idx_reg, s1_idx_next;
    logic [63:0]      s1_st_reg, s1_st_next;
    logic [63:0]      s1_en_reg, s1_en_next;
    logic [63:0]      s1_fend_reg, s1_fend_next;
    logic             s1_ok_reg, s1_ok_next;

    logic             last;
    logic             in_cnt;
    logic [CNT_W-1:0] c_cnt;
    logic [63:0]      hend, h_st, h_en;
    logic             h_st_ok;
    logic [63:0]      s2_len;
    logic             s2_qual, s2_exact;
    logic             merge_now, ins_now, drop_now, again, out_free;
    logic             resv_active, resv_hit;

    assign last     = (c_reg == LAST_IDX);
    assign c_cnt    = CNT_W'(c_reg);
    assign in_cnt   = (c_cnt < count_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign hend     = head.base + head.length;
    assign h_st     = (head.base + PG_MASK) & ~PG_MASK;
    assign h_st_ok  = (head.base <= ST_LIMIT);
    assign h_en     = hend & ~PG_MASK;
    assign s2_len   = (s1_en_reg > s1_st_reg) ? s1_en_reg - s1_st_reg : 64'd0;
    assign s2_exact = (s2_len == size_reg);
    assign s2_qual  = s1_valid_reg && s1_ok_reg && (s2_len >= size_reg)
                      && ((s1_st_reg + size_reg) <= req_reg.alloc_limit)
                      && (s2_exact || ((count_reg < MAX_CNT)
                                       && (s1_en_reg <= req_reg.alloc_limit)));
    assign resv_active = (SCN_W'(c_reg) >= scan_reg) && in_cnt && !stopped_reg
                         && !inserted_reg;
    assign resv_hit = (head.rtype == TYPE_RAM) && !(hend <= req_reg.reserve_start)
                      && !(head.base >= req_reg.reserve_end);

    // next state
    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        c_next     = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    priority case (req.operation)
                        OP_APPEND: begin
                            state_next = S_PASS;
                            pass_next  = PS_APPEND;
                        end
                        OP_READ: begin
                            state_next = S_PASS;
                            pass_next  = PS_READ;
                        end
                        OP_ALLOC: begin
                            state_next = (req.alloc_size <= ST_LIMIT) ? S_PASS : S_DONE;
                            pass_next  = PS_ASCAN;
                        end
                        OP_RESERVE: begin
                            state_next = (req.reserve_start < req.reserve_end) ?
                                         S_PASS : S_DONE;
                            pass_next  = PS_RESV;
                        end
                        OP_COMPACT: begin
                            state_next = S_PASS;
                            pass_next  = PS_CTRANS;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_PASS: begin
                c_next = last ? '0 : c_reg + IDX_W'(1);
                if (last) begin
                    unique case (pass_reg)
                        PS_ASCAN:  state_next = S_DRAIN;
                        PS_CTRANS: pass_next  = PS_CDROP;
                        PS_RESV, PS_CDROP: state_next = again ? S_PASS : S_DONE;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_DRAIN: state_next = found_next ? S_CALC : S_DONE;
            S_CALC: begin
                state_next = S_PASS;
                pass_next  = PS_AAPPLY;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        tail          = head;
        req_next      = req_reg;
        rsp_next      = rsp_reg;
        count_next    = count_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        merged_next   = merged_reg;
        found_next    = found_reg;
        exact_next    = exact_reg;
        inserted_next = inserted_reg;
        stopped_next  = stopped_reg;
        skip_next     = skip_reg;
        scan_next     = scan_reg;
        size_next     = size_reg;
        status_next   = status_reg;
        addr_next     = addr_reg;
        rd_next       = rd_reg;
        pend_next     = pend_reg;
        k_next        = k_reg;
        cand_next     = cand_reg;
        fend_next     = fend_reg;
        nl_next       = nl_reg;
        merge_now     = 1'b0;
        ins_now       = 1'b0;
        drop_now      = 1'b0;
        again         = 1'b0;
        s1_valid_next = (state_reg == S_PASS) && (pass_reg == PS_ASCAN) && in_cnt;
        s1_idx_next   = c_reg;
        s1_st_next    = h_st;
        s1_en_next    = h_en;
        s1_fend_next  = hend;
        s1_ok_next    = (head.rtype == TYPE_RAM) && h_st_ok;

        if (s2_qual) begin
            found_next = 1'b1;
            k_next     = s1_idx_reg;
            exact_next = s2_exact;
            cand_next  = s2_exact ? s1_st_reg : s1_en_reg - size_reg;
            fend_next  = s1_fend_reg;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next      = req;
                    status_next   = STS_OK;
                    addr_next     = '0;
                    rd_next       = '0;
                    merged_next   = 1'b0;
                    found_next    = 1'b0;
                    inserted_next = 1'b0;
                    stopped_next  = 1'b0;
                    skip_next     = 1'b0;
                    scan_next     = '0;
                    size_next     = (req.alloc_size + PG_MASK) & ~PG_MASK;
                    if (req.operation == OP_ALLOC && req.alloc_size > ST_LIMIT) begin
                        status_next = STS_NOFIT;
                    end
                end
            end
            S_PASS: begin
                unique case (pass_reg)
                    PS_APPEND: begin
                        if (count_reg != '0 && c_cnt == count_reg - CNT_W'(1) && merge_en
                            && head.rtype == req_reg.entry_type
                            && req_reg.entry_base == hend) begin
                            tail.length = head.length + req_reg.entry_length;
                            merge_now   = 1'b1;
                            merged_next = 1'b1;
                        end
                        if (c_cnt == count_reg && !merged_reg) begin
                            tail = '{req_reg.entry_base, req_reg.entry_length,
                                     req_reg.entry_type};
                        end
                        if (last) begin
                            if (!(merged_reg || merge_now)) begin
                                if (count_reg < MAX_CNT) begin
                                    count_next = count_reg + CNT_W'(1);
                                end else begin
                                    status_next = STS_FULL;
                                end
                            end
                        end
                    end
                    PS_READ: begin
                        if (RI_W'(c_reg) == RI_W'(req_reg.read_index)
                            && RI_W'(req_reg.read_index) < RI_W'(count_reg)) begin
                            rd_next = head;
                        end
                    end
                    PS_ASCAN: begin
                    end
                    PS_AAPPLY: begin
                        if (c_reg == k_reg) begin
                            if (exact_reg) begin
                                tail.rtype = TYPE_RESERVED;
                            end else begin
                                tail.length = head.length - nl_reg;
                            end
                        end
                        if (!exact_reg && c_cnt == count_reg) begin
                            tail = '{cand_reg, nl_reg, TYPE_RESERVED};
                        end
                        if (last) begin
                            if (!exact_reg) begin
                                count_next = count_reg + CNT_W'(1);
                            end
                            addr_next   = cand_reg;
                            status_next = (cand_reg == '0) ? STS_NOFIT : STS_OK;
                        end
                    end
                    PS_RESV: begin
                        if (inserted_reg) begin
                            tail      = pend_reg;
                            pend_next = head;
                        end else if (resv_active && resv_hit) begin
                            if (head.base > req_reg.reserve_start
                                || hend < req_reg.reserve_end) begin
                                status_next  = STS_CROSS;
                                stopped_next = 1'b1;
                            end else if (req_reg.reserve_end < hend) begin
                                if (count_reg >= MAX_CNT) begin
                                    status_next  = STS_FULL;
                                    stopped_next = 1'b1;
                                end else begin
                                    tail.length   = req_reg.reserve_start - head.base;
                                    pend_next     = '{req_reg.reserve_end,
                                                      hend - req_reg.reserve_end,
                                                      TYPE_RAM};
                                    ins_now       = 1'b1;
                                    inserted_next = 1'b1;
                                    scan_next     = SCN_W'(c_reg) + SCN_W'(2);
                                end
                            end else begin
                                tail.length = req_reg.reserve_start - head.base;
                            end
                        end
                        if (last) begin
                            if (inserted_reg || ins_now) begin
                                count_next    = count_reg + CNT_W'(1);
                                again         = 1'b1;
                                inserted_next = 1'b0;
                            end
                        end
                    end
                    PS_CTRANS: begin
                        if (in_cnt) begin
                            if (h_st_ok && h_st < h_en) begin
                                tail = '{h_st, h_en - h_st, head.rtype};
                            end else begin
                                tail.length = '0;
                            end
                        end
                        if (last) begin
                            skip_next = 1'b0;
                        end
                    end
                    PS_CDROP: begin
                        if (skip_reg) begin
                            tail = nxt;
                        end else if (in_cnt && head.length == '0) begin
                            tail      = nxt;
                            drop_now  = 1'b1;
                            skip_next = 1'b1;
                        end
                        if (last) begin
                            skip_next = 1'b0;
                            if (skip_reg || drop_now) begin
                                count_next = count_reg - CNT_W'(1);
                                again      = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_DRAIN: begin
                if (!found_next) begin
                    status_next = STS_NOFIT;
                end
            end
            S_CALC: begin
                nl_next = fend_reg - cand_reg;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    rsp_next     = '{status_reg, addr_reg, rd_reg.base, rd_reg.length,
                                     rd_reg.rtype, 6'(count_reg)};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            pass_reg     <= PS_APPEND;
            c_reg        <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            merged_reg   <= 1'b0;
            found_reg    <= 1'b0;
            exact_reg    <= 1'b0;
            inserted_reg <= 1'b0;
            stopped_reg  <= 1'b0;
            skip_reg     <= 1'b0;
            scan_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            pass_reg     <= pass_next;
            c_reg        <= c_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
            s1_valid_reg <= s1_valid_next;
            merged_reg   <= merged_next;
            found_reg    <= found_next;
            exact_reg    <= exact_next;
            inserted_reg <= inserted_next;
            stopped_reg  <= stopped_next;
            skip_reg     <= skip_next;
            scan_reg     <= scan_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        rsp_reg     <= rsp_next;
        size_reg    <= size_next;
        status_reg  <= status_next;
        addr_reg    <= addr_next;
        rd_reg      <= rd_next;
        pend_reg    <= pend_next;
        k_reg       <= k_next;
        cand_reg    <= cand_next;
        fend_reg    <= fend_next;
        nl_reg      <= nl_next;
        s1_idx_reg  <= s1_idx_next;
        s1_st_reg   <= s1_st_next;
        s1_en_reg   <= s1_en_next;
        s1_fend_reg <= s1_fend_next;
        s1_ok_reg   <= s1_ok_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign shift   = (state_reg == S_PASS);
    assign m_valid = m_valid_reg;
    assign rsp     = rsp_reg;

endmodule
`default_nettype wire

FILE: sv/memory_map_region_table.sv
// Region table held in a ring of MAX_REGIONS cells; each pass of an operation rotates the ring
// once, the controller working on the cell at the head.
// Append and read use one pass; allocate a scan pass, then an apply pass if a region fits.
// Reserve (start below end): one pass plus one per inserted remainder; compact: two passes
// plus one per dropped entry. One item at a time.
// Synchronous active-low reset empties the table and clears merging.
`default_nettype none
module memory_map_region_table #(
    parameter int MAX_REGIONS = 32,
    parameter int PAGE_BITS   = 12
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire  [0:0]   cfg_data,      // merge_adjacent
    input  wire          s_tvalid,
    output logic         s_tready,
    // operation, entry_base, entry_length, entry_type, alloc_size, alloc_limit,
    // reserve_start, reserve_end, read_index
    input  wire  [423:0] s_tdata,
    output logic         m_tvalid,
    input  wire          m_tready,
    // status, alloc_address, read_base, read_length, read_type, entries_used
    output logic [231:0] m_tdata
);
    import mmrt_pkg::*;

    logic   merge_reg;
    req_t   req;
    rsp_t   rsp;
    entry_t tail;
    logic   shift;
    entry_t ring [MAX_REGIONS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            merge_reg <= 1'b0;
        end else if (cfg_valid) begin
            merge_reg <= cfg_data[0];
        end
    end
    assign cfg_ready = 1'b1;

    assign req.operation     = s_tdata[2:0];
    assign req.entry_base    = s_tdata[66:3];
    assign req.entry_length  = s_tdata[130:67];
    assign req.entry_type    = s_tdata[162:131];
    assign req.alloc_size    = s_tdata[226:163];
    assign req.alloc_limit   = s_tdata[290:227];
    assign req.reserve_start = s_tdata[354:291];
    assign req.reserve_end   = s_tdata[418:355];
    assign req.read_index    = s_tdata[423:419];

    for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
        mmrt_cell u_cell (
            .aclk  (aclk),
            .shift (shift),
            .d_in  ((i == MAX_REGIONS - 1) ? tail : ring[(i + 1) % MAX_REGIONS]),
            .q     (ring[i])
        );
    end

    mmrt_ctrl #(
        .MAX_REGIONS (MAX_REGIONS),
        .PAGE_BITS   (PAGE_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .req      (req),
        .merge_en (merge_reg),
        .head     (ring[0]),
        .nxt      (ring[1]),
        .shift    (shift),
        .tail     (tail),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .rsp      (rsp)
    );

    assign m_tdata = {rsp.entries_used, rsp.read_type, rsp.read_length, rsp.read_base,
                      rsp.alloc_address, rsp.status};

endmodule
`default_nettype wire

FILE: dv/memory_map_region_table_tb.sv
module memory_map_region_table_tb;
    import mmrt_pkg::*;

    localparam int          NREG    = 32;
    localparam logic [63:0] PG_MASK = 64'hFFF;
    localparam logic [63:0] ALL1    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          IDLE_LIMIT = 20000;

    typedef struct {
        logic [2:0]  op;
        logic [63:0] eb, el;
        logic [31:0] et;
        logic [63:0] asz, alim;
        logic [63:0] rs, re;
        logic [4:0]  ri;
    } req_s;

    typedef struct {
        status_t     st;
        logic [63:0] aa, rbase, rlen;
        logic [31:0] rtyp;
        logic [5:0]  used;
    } rsp_s;

    typedef struct {
        req_s rq;
        bit   chk;
        rsp_s ex;
    } row_s;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [0:0]   cfg_data = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [423:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [231:0] m_tdata;

    memory_map_region_table DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    // region table shadow
    logic [63:0] tbl_base [NREG];
    logic [63:0] tbl_len  [NREG];
    logic [31:0] tbl_type [NREG];
    int          tbl_cnt;
    bit          merge_on;

    rsp_s        exp_rsp_q[$];
    int          errs;
    int          burst_left;
    logic [63:0] cursor;

    function automatic bit page_up(input logic [63:0] x, output logic [63:0] r);
        if (x > ALL1 - PG_MASK) return 1'b0;
        r = (x + PG_MASK) & ~PG_MASK;
        return 1'b1;
    endfunction

    function automatic void put(int i, logic [63:0] b, logic [63:0] l, logic [31:0] t);
        tbl_base[i] = b;
        tbl_len[i]  = l;
        tbl_type[i] = t;
    endfunction

    function automatic status_t region_append(logic [63:0] b, logic [63:0] l, logic [31:0] t);
        int p;
        if (merge_on && tbl_cnt > 0) begin
            p = tbl_cnt - 1;
            if (tbl_type[p] == t && b == tbl_base[p] + tbl_len[p]) begin
                tbl_len[p] += l;
                return STS_OK;
            end
        end
        if (tbl_cnt >= NREG) return STS_FULL;
        put(tbl_cnt, b, l, t);
        tbl_cnt++;
        return STS_OK;
    endfunction

    function automatic status_t region_alloc(logic [63:0] sreq, logic [63:0] lim,
                                             output logic [63:0] addr);
        logic [63:0] size, st, en, ln, fe, nb, nl;
        int k;
        addr = '0;
        if (!page_up(sreq, size)) return STS_NOFIT;
        for (int i = tbl_cnt; i > 0; i--) begin
            k = i - 1;
            fe = tbl_base[k] + tbl_len[k];
            if (tbl_type[k] != TYPE_RAM || !page_up(tbl_base[k], st)) continue;
            en = fe & ~PG_MASK;
            ln = (en > st) ? en - st : 64'd0;
            if (ln < size || st + size > lim) continue;
            if (ln == size) begin
                tbl_type[k] = TYPE_RESERVED;
                addr = st;
                break;
            end
            if (tbl_cnt < NREG && en <= lim) begin
                nb = en - size;
                nl = fe - nb;
                put(tbl_cnt, nb, nl, TYPE_RESERVED);
                tbl_len[k] -= nl;
                tbl_cnt++;
                addr = nb;
                break;
            end
        end
        return (addr == 0) ? STS_NOFIT : STS_OK;
    endfunction

    function automatic status_t region_reserve(logic [63:0] s, logic [63:0] e);
        logic [63:0] es, ee;
        if (s >= e) return STS_OK;
        for (int i = 0; i < tbl_cnt; i++) begin
            es = tbl_base[i];
            ee = es + tbl_len[i];
            if (tbl_type[i] != TYPE_RAM || ee <= s || es >= e) continue;
            if (es > s || ee < e) return STS_CROSS;
            if (e < ee) begin
                if (tbl_cnt >= NREG) return STS_FULL;
                for (int j = tbl_cnt; j > i + 1; j--)
                    put(j, tbl_base[j-1], tbl_len[j-1], tbl_type[j-1]);
                put(i + 1, e, ee - e, TYPE_RAM);
                tbl_cnt++;
            end
            tbl_len[i] = s - es;
        end
        return STS_OK;
    endfunction

    function automatic void region_compact();
        logic [63:0] st, en;
        int n;
        n = 0;
        for (int i = 0; i < tbl_cnt; i++) begin
            if (!page_up(tbl_base[i], st)) continue;
            en = (tbl_base[i] + tbl_len[i]) & ~PG_MASK;
            if (st < en) begin
                put(n, st, en - st, tbl_type[i]);
                n++;
            end
        end
        for (int i = n; i < tbl_cnt; i++) put(i, '0, '0, '0);
        tbl_cnt = n;
    endfunction

    function automatic rsp_s table_predict(req_s r);
        rsp_s o;
        o = '{STS_OK, '0, '0, '0, '0, '0};
        case (r.op)
            OP_APPEND:  o.st = region_append(r.eb, r.el, r.et);
            OP_ALLOC: begin
                o.st = region_alloc(r.asz, r.alim, o.aa);
                if (o.st != STS_OK) o.aa = '0;
            end
            OP_RESERVE: o.st = region_reserve(r.rs, r.re);
            OP_COMPACT: region_compact();
            OP_READ: begin
                if (r.ri < tbl_cnt) begin
                    o.rbase = tbl_base[r.ri];
                    o.rlen  = tbl_len[r.ri];
                    o.rtyp  = tbl_type[r.ri];
                end
            end
            default: ;
        endcase
        o.used = tbl_cnt[5:0];
        return o;
    endfunction

    function automatic req_s mk(logic [2:0] op, logic [63:0] p0, logic [63:0] p1,
                                logic [31:0] p2);
        req_s r;
        r = '{op, '0, '0, '0, '0, '0, '0, '0, '0};
        case (op)
            OP_APPEND:  begin r.eb = p0; r.el = p1; r.et = p2; end
            OP_ALLOC:   begin r.asz = p0; r.alim = p1; end
            OP_RESERVE: begin r.rs = p0; r.re = p1; end
            OP_READ:    r.ri = p0[4:0];
            OP_COMPACT: ;
            default: r = '{op, ALL1, ALL1, '1, ALL1, ALL1, ALL1, ALL1, '1};
        endcase
        return r;
    endfunction

    function automatic row_s row(req_s r, bit chk, status_t st, logic [5:0] used);
        row_s w;
        w.rq  = r;
        w.chk = chk;
        w.ex  = '{st, '0, '0, '0, '0, used};
        return w;
    endfunction

    task automatic send_item(req_s r, bit chk, rsp_s ex);
        rsp_s p;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 10);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r.ri, r.re, r.rs, r.alim, r.asz, r.et, r.el, r.eb, r.op};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        p = table_predict(r);
        exp_rsp_q.push_back(chk ? ex : p);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (exp_rsp_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_merge(bit v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        merge_on = v;
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic req_s random_item();
        req_s r;
        logic [63:0] es, ee, rem;
        int w, k;
        r = '{$urandom_range(0, 7), rnd64(), rnd64(), $urandom, rnd64(), rnd64(),
              rnd64(), rnd64(), $urandom_range(0, 31)};
        w = $urandom_range(0, 99);
        if (w < 35) begin
            r.op = OP_APPEND;
            if ($urandom_range(0, 9) < 8) begin
                r.eb = ($urandom_range(0, 1) == 0) ? cursor : {32'h0, $urandom & ~32'hFFF};
                r.el = 64'($urandom_range(0, 16)) << 12;
                if ($urandom_range(0, 7) == 0) r.el += $urandom_range(0, 4095);
                if ($urandom_range(0, 7) == 0) r.eb += $urandom_range(1, 4095);
                r.et = ($urandom_range(0, 9) < 8) ? TYPE_RAM :
                       ($urandom_range(0, 1) ? TYPE_RESERVED : $urandom);
            end
            cursor = r.eb + r.el;
        end else if (w < 55) begin
            r.op = OP_ALLOC;
            if ($urandom_range(0, 9) < 9) begin
                r.asz  = $urandom_range(0, 32'h9000);
                r.alim = $urandom_range(0, 2) ? ALL1 : {32'h0, $urandom};
            end
        end else if (w < 72) begin
            r.op = OP_RESERVE;
            if (tbl_cnt > 0 && $urandom_range(0, 9) < 9) begin
                k  = $urandom_range(0, tbl_cnt - 1);
                es = tbl_base[k];
                ee = es + tbl_len[k];
                case ($urandom_range(0, 3))
                    0: begin r.rs = es; r.re = ee; end
                    1: begin
                        r.rs = (tbl_len[k] == 0) ? es : es + rnd64() % tbl_len[k];
                        rem  = ee - r.rs;
                        r.re = (rem == 0) ? r.rs : r.rs + 1 + rnd64() % rem;
                    end
                    2: begin r.rs = es - 1; r.re = es + 1; end
                    default: begin r.rs = ee; r.re = es; end
                endcase
            end
        end else if (w < 78) begin
            r.op = OP_COMPACT;
        end else if (w < 96) begin
            r.op = OP_READ;
        end else begin
            r.op = $urandom_range(5, 7);
        end
        return r;
    endfunction

    always @(posedge aclk) begin : result_check
        rsp_s got, ex;
        int   cyc;
        int   mode;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{status_t'(m_tdata[1:0]), m_tdata[65:2], m_tdata[129:66],
                    m_tdata[193:130], m_tdata[225:194], m_tdata[231:226]};
            if (exp_rsp_q.size() == 0) begin
                $error("unexpected result item");
                errs++;
            end else begin
                ex = exp_rsp_q.pop_front();
                if (got.st !== ex.st) begin
                    $error("status exp %0d got %0d", ex.st, got.st); errs++;
                end
                if (got.aa !== ex.aa) begin
                    $error("alloc_address exp %h got %h", ex.aa, got.aa); errs++;
                end
                if (got.rbase !== ex.rbase) begin
                    $error("read_base exp %h got %h", ex.rbase, got.rbase); errs++;
                end
                if (got.rlen !== ex.rlen) begin
                    $error("read_length exp %h got %h", ex.rlen, got.rlen); errs++;
                end
                if (got.rtyp !== ex.rtyp) begin
                    $error("read_type exp %h got %h", ex.rtyp, got.rtyp); errs++;
                end
                if (got.used !== ex.used) begin
                    $error("entries_used exp %0d got %0d", ex.used, got.used); errs++;
                end
            end
        end
        cyc++;
        mode = (cyc / 700) % 3;
        case (mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    always @(posedge aclk) begin : watchdog
        int idle;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle = 0;
        else
            idle++;
        if (idle >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        row_s rows[$];
        rsp_s none;
        none = '{STS_OK, '0, '0, '0, '0, '0};
        errs = 0;
        burst_left = 0;
        cursor = 64'h10_0000;
        tbl_cnt = 0;
        merge_on = 1'b0;
        for (int i = 0; i < NREG; i++) put(i, '0, '0, '0);

        rows.push_back(row(mk(OP_READ, 0, 0, 0), 1, STS_OK, 0));
        rows.push_back(row(mk(OP_APPEND, 64'h1000, 64'h1_0000, TYPE_RAM), 1, STS_OK, 1));
        rows.push_back(row(mk(OP_APPEND, 64'h1_1000, 64'h1000, TYPE_RAM), 1, STS_OK, 2));
        rows.push_back(row(mk(3'd7, 0, 0, 0), 1, STS_OK, 2));
        rows.push_back(row(mk(OP_ALLOC, ALL1, ALL1, 0), 1, STS_NOFIT, 2));
        rows.push_back(row(mk(OP_ALLOC, 64'h1000, 64'h0, 0), 1, STS_NOFIT, 2));
        rows.push_back(row(mk(OP_ALLOC, 64'h1, ALL1, 0), 0, STS_OK, 0));
        rows.push_back(row(mk(OP_ALLOC, 64'h1000, 64'h1_1000, 0), 0, STS_OK, 0));
        rows.push_back(row(mk(OP_RESERVE, 64'h5, 64'h5, 0), 0, STS_OK, 0));
        rows.push_back(row(mk(OP_RESERVE, 64'h2000, 64'h3000, 0), 0, STS_OK, 0));
        rows.push_back(row(mk(OP_RESERVE, 64'h1000, 64'h12000, 0), 0, STS_OK, 0));
        rows.push_back(row(mk(OP_APPEND, 64'h0, 64'h1000, TYPE_RAM), 0, STS_OK, 0));
        rows.push_back(row(mk(OP_ALLOC, 64'h1000, 64'h1000, 0), 0, STS_OK, 0));
        rows.push_back(row(mk(OP_APPEND, ALL1, ALL1, 32'hFFFF_FFFF), 0, STS_OK, 0));
        rows.push_back(row(mk(OP_APPEND, 64'h3_0800, 64'h1900, 32'h7), 0, STS_OK, 0));
        rows.push_back(row(mk(OP_RESERVE, 64'h0, ALL1, 0), 0, STS_OK, 0));
        rows.push_back(row(mk(OP_COMPACT, 0, 0, 0), 0, STS_OK, 0));
        rows.push_back(row(mk(OP_READ, 0, 0, 0), 0, STS_OK, 0));
        rows.push_back(row(mk(OP_READ, 1, 0, 0), 0, STS_OK, 0));
        rows.push_back(row(mk(OP_READ, 2, 0, 0), 0, STS_OK, 0));
        rows.push_back(row(mk(OP_READ, 31, 0, 0), 0, STS_OK, 0));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_merge(1'b0);

        foreach (rows[i]) send_item(rows[i].rq, rows[i].chk, rows[i].ex);

        for (int ph = 0; ph < 4; ph++) begin
            write_merge(ph % 2 == 0);
            for (int n = 0; n < 400; n++) begin
                if ($urandom_range(0, 149) == 0) wait_drained();
                send_item(random_item(), 0, none);
            end
        end

        wait_drained();
        repeat (100) @(posedge aclk);
        if (errs == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
